>>> hdl/cdq_pkg.sv
// ---------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Item formats, operation codes, pointer helpers and the
// control/status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH      = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    MODE_PUSH_REAR  = 2'd0,
    MODE_POP_FRONT  = 2'd1,
    MODE_POP_REAR   = 2'd2,
    MODE_PUSH_FRONT = 2'd3
  } mode_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    mode_t                 mode;
    logic [ELEM_WIDTH-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic                  done_res;
    logic [ELEM_WIDTH-1:0] pop_value;
    logic                  is_empty;
    logic                  is_full;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // request transfer this cycle
    logic fetch_done;  // slot read data is valid, load it into the result
  } cdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic res_valid;   // result register holds an untaken result
    logic pop_go;      // current request is a pop that will succeed
  } cdq_status_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic ptr_t ptr_prev(input ptr_t p);
    if (p == '0) begin
      return PTR_W'(DEPTH - 1);
    end
    return p - 1'b1;
  endfunction

endpackage

>>> hdl/cdq_ram.sv
// ---------------------------------------------------------------------------
// cdq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/cdq_ctrl.sv
// ---------------------------------------------------------------------------
// cdq_ctrl: deque controller
// Sequences request acceptance and the S_READ state a successful pop
// spends waiting on the slot RAM read.
// ---------------------------------------------------------------------------
module cdq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic                 rsp_ready,
  input  cdq_pkg::cdq_status_t status,
  output cdq_pkg::cdq_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // no transfers during reset; result register must be free, or freed by
  // this cycle's transfer
  assign req_ready = !rst && (state == S_IDLE) && (!status.res_valid || rsp_ready);

  always_comb begin
    state_next     = state;
    cmd.accept     = 1'b0;
    cmd.fetch_done = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = req_valid && req_ready;
        if (cmd.accept && status.pop_go) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.fetch_done = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/cdq_dp.sv
// ---------------------------------------------------------------------------
// cdq_dp: deque datapath
// Head/tail pointers, slot RAM and the result register.
// ---------------------------------------------------------------------------
module cdq_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  cdq_pkg::req_t        req,
  input  cdq_pkg::cdq_cmd_t    cmd,
  output cdq_pkg::cdq_status_t status,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output cdq_pkg::rsp_t        rsp
);

  cdq_pkg::ptr_t head;
  cdq_pkg::ptr_t head_next;
  cdq_pkg::ptr_t tail;
  cdq_pkg::ptr_t tail_next;
  cdq_pkg::ptr_t waddr;
  cdq_pkg::ptr_t raddr;

  logic                           we;
  logic                           ok;
  logic                           is_pop;
  logic                           empty;
  logic                           full;
  logic [cdq_pkg::ELEM_WIDTH-1:0] rdata;

  cdq_pkg::rsp_t res;
  logic          res_valid;
  logic          res_valid_next;

  assign empty = (head == tail);
  assign full  = (cdq_pkg::ptr_next(tail) == head);

  always_comb begin
    head_next = head;
    tail_next = tail;
    we        = 1'b0;
    ok        = 1'b0;
    is_pop    = 1'b0;
    waddr     = cdq_pkg::ptr_next(tail);
    raddr     = tail;
    unique case (req.mode)
      cdq_pkg::MODE_PUSH_REAR: begin
        ok    = !full;
        waddr = cdq_pkg::ptr_next(tail);
        if (cmd.accept && ok) begin
          we        = 1'b1;
          tail_next = cdq_pkg::ptr_next(tail);
        end
      end
      cdq_pkg::MODE_POP_FRONT: begin
        is_pop = 1'b1;
        ok     = !empty;
        raddr  = cdq_pkg::ptr_next(head);
        if (cmd.accept && ok) begin
          head_next = cdq_pkg::ptr_next(head);
        end
      end
      cdq_pkg::MODE_POP_REAR: begin
        is_pop = 1'b1;
        ok     = !empty;
        raddr  = tail;
        if (cmd.accept && ok) begin
          tail_next = cdq_pkg::ptr_prev(tail);
        end
      end
      cdq_pkg::MODE_PUSH_FRONT: begin
        ok    = !full;
        waddr = head;
        if (cmd.accept && ok) begin
          we        = 1'b1;
          head_next = cdq_pkg::ptr_prev(head);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign status.pop_go    = is_pop && ok;
  assign status.res_valid = res_valid;

  cdq_ram #(
    .WIDTH (cdq_pkg::ELEM_WIDTH),
    .DEPTH (cdq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (req.push_value),
    .re    (cmd.accept && status.pop_go),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  // pushes and refused ops finish at the transfer; pops load data in the following cycle (S_READ)
  always_comb begin
    res_valid_next = res_valid;
    if (rsp_valid && rsp_ready) begin
      res_valid_next = 1'b0;
    end
    if ((cmd.accept && !status.pop_go) || cmd.fetch_done) begin
      res_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res.done_res  <= ok;
      res.pop_value <= '0;
      res.is_empty  <= (head_next == tail_next);
      res.is_full   <= (cdq_pkg::ptr_next(tail_next) == head_next);
    end
    if (cmd.fetch_done) begin
      res.pop_value <= rdata;
    end
  end

  assign rsp_valid = res_valid;
  assign rsp       = res;

endmodule

>>> hdl/circular_deque.sv
// ---------------------------------------------------------------------------
// circular_deque: ring-buffer double-ended queue
// Push/pop at either end of a DEPTH-slot ring; holds at most DEPTH-1 entries.
// ---------------------------------------------------------------------------
// Response: a push or a refused op has its result registered at the request
//   transfer; a successful pop loads its slot RAM read data from S_READ.
// Throughput: one request per cycle for pushes while rsp_ready holds; a pop
//   blocks further requests until its registered slot RAM read lands in S_READ.
// Reset: rst (sync, active high) empties the deque and drops any pending
//   result; slot contents are not cleared.
module circular_deque (
  input  logic           clk,
  input  logic           rst,
  // request channel
  input  logic           req_valid,
  output logic           req_ready,
  input  cdq_pkg::req_t  req,
  // response channel
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cdq_pkg::rsp_t  rsp
);

  // Controller/datapath split: the controller only decides when a request
  // transfers and when pop read data lands; all pointer and slot logic is in
  // the datapath.
  cdq_pkg::cdq_cmd_t    cmd;
  cdq_pkg::cdq_status_t status;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: head points at the free slot before the first entry, tail at
  // the last entry. Empty/full flags in the result reflect the post-op state.
  // The result register decouples the response side, so a new request can
  // transfer in the same cycle the previous result is taken.
  cdq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
